### rtl/lsp_pkg.sv
package lsp_pkg;

	localparam int CNT_W = 4;

	typedef enum logic [1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_TOUCH   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_FIND    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACQ_FREE     = 2'd0,
		ACQ_RECYCLED = 2'd1,
		ACQ_FAILED   = 2'd2,
		ACQ_NONE     = 2'd3
	} acq_status_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] conn_id;
		logic [7:0]  slot_index;
		logic [31:0] now_stamp;
	} req_t;

	typedef struct packed {
		acq_status_t      acq_status;
		logic             ok;
		logic [2:0]       slot_out;
		logic             evicted_valid;
		logic [31:0]      displaced_id;
		logic [CNT_W-1:0] busy_count;
	} rsp_t;

endpackage

### rtl/lsp_ram.sv
module lsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/lru_slot_pool.sv
// A command is taken by start while idle; the pool then scans the slot memories, one entry a
// cycle, over the effective slot count n (min(active_slots, SLOTS)), passes a final state and
// strobes done with the result. No new command is taken before the result is shown; the next
// start is taken in the cycle its predecessor's result is shown.
// Reset clears busy flags, control state and sets active_slots to 8; the id and stamp
// memories are not cleared, as an entry is only used while its busy flag is set. No stall.
module lru_slot_pool #(
	parameter int SLOTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  lsp_pkg::req_t                req,
	output logic                         done,
	output lsp_pkg::rsp_t                rsp,
	input  logic                         cfg_we,
	input  logic [lsp_pkg::CNT_W-1:0]    cfg_wdata
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = lsp_pkg::CNT_W;
	localparam logic [CW-1:0] SLOTS_C = (SLOTS > 15) ? CW'(15) : CW'(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    active_q;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    iss_q;
	logic             vld_s1;
	logic [CW-1:0]    idx_s1;
	logic [SLOTS-1:0] busy_q;
	logic             done_q;
	lsp_pkg::rsp_t    rsp_q;

	lsp_pkg::req_t    req_q;
	logic [CW-1:0]    cnt_q;
	logic             free_hit_q;
	logic [CW-1:0]    free_idx_q;
	logic [CW-1:0]    lru_idx_q;
	logic [31:0]      lru_stamp_q;
	logic [31:0]      lru_conn_q;
	logic             find_hit_q;
	logic [CW-1:0]    find_idx_q;

	logic [CW-1:0]    eff_n;
	logic             accept;
	logic             rd_en;
	logic [31:0]      conn_rd;
	logic [31:0]      stamp_rd;
	logic             ent_busy;

	logic             conn_we;
	logic             stamp_we;
	logic [CW-1:0]    wr_slot;
	logic             set_busy;
	logic             clr_busy;
	lsp_pkg::rsp_t    rsp_d;
	logic             idx_ok;

	assign eff_n  = (active_q < SLOTS_C) ? active_q : SLOTS_C;
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	assign rd_en    = (state_q == ST_SCAN) && (iss_q < n_q);
	assign ent_busy = busy_q[IW'(idx_s1)];
	assign idx_ok   = (req_q.slot_index < 8'(n_q)) && busy_q[IW'(req_q.slot_index)];

	// Reads happen only in the scan and writes only in the final state, so the same entry
	// never sees a read and a write together.
	lsp_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_conn_ram (
		.clk   (clk),
		.we    (conn_we),
		.waddr (IW'(wr_slot)),
		.wdata (req_q.conn_id),
		.re    (rd_en),
		.raddr (IW'(iss_q)),
		.rdata (conn_rd)
	);

	lsp_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (IW'(wr_slot)),
		.wdata (req_q.now_stamp),
		.re    (rd_en),
		.raddr (IW'(iss_q)),
		.rdata (stamp_rd)
	);

	always_comb begin
		conn_we  = 1'b0;
		stamp_we = 1'b0;
		set_busy = 1'b0;
		clr_busy = 1'b0;
		wr_slot  = free_idx_q;
		rsp_d    = '0;
		rsp_d.acq_status = lsp_pkg::ACQ_NONE;
		rsp_d.busy_count = cnt_q;
		if (state_q == ST_FIN) begin
			case (req_q.cmd)
				lsp_pkg::CMD_ACQUIRE: begin
					if (n_q == '0) begin
						rsp_d.acq_status = lsp_pkg::ACQ_FAILED;
					end else begin
						conn_we  = 1'b1;
						stamp_we = 1'b1;
						set_busy = 1'b1;
						if (free_hit_q) begin
							wr_slot             = free_idx_q;
							rsp_d.acq_status    = lsp_pkg::ACQ_FREE;
							rsp_d.busy_count    = cnt_q + CW'(1);
						end else begin
							wr_slot             = lru_idx_q;
							rsp_d.acq_status    = lsp_pkg::ACQ_RECYCLED;
							rsp_d.evicted_valid = 1'b1;
							rsp_d.displaced_id  = lru_conn_q;
						end
						rsp_d.slot_out = wr_slot[2:0];
					end
				end
				lsp_pkg::CMD_TOUCH: begin
					wr_slot  = CW'(req_q.slot_index);
					stamp_we = idx_ok;
					rsp_d.ok = idx_ok;
				end
				lsp_pkg::CMD_RELEASE: begin
					wr_slot  = CW'(req_q.slot_index);
					clr_busy = idx_ok;
					rsp_d.ok = idx_ok;
					if (idx_ok) begin
						rsp_d.busy_count = cnt_q - CW'(1);
					end
				end
				lsp_pkg::CMD_FIND: begin
					rsp_d.ok = find_hit_q;
					if (find_hit_q) begin
						rsp_d.slot_out = find_idx_q[2:0];
					end
				end
				default: begin
					rsp_d.acq_status = lsp_pkg::ACQ_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= CW'(8);
			n_q      <= '0;
			iss_q    <= '0;
			vld_s1   <= 1'b0;
			busy_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q     <= eff_n;
						iss_q   <= '0;
						vld_s1  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						iss_q <= iss_q + CW'(1);
					end
					if (!rd_en && !vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (set_busy) begin
						busy_q[IW'(wr_slot)] <= 1'b1;
					end
					if (clr_busy) begin
						busy_q[IW'(wr_slot)] <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q;
		if (state_q == ST_FIN) begin
			rsp_q <= rsp_d;
		end
		if (accept) begin
			req_q      <= req;
			cnt_q      <= '0;
			free_hit_q <= 1'b0;
			free_idx_q <= '0;
			find_hit_q <= 1'b0;
			find_idx_q <= '0;
			lru_idx_q  <= '0;
		end else if (state_q == ST_SCAN && vld_s1) begin
			if (ent_busy) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (!ent_busy && !free_hit_q) begin
				free_hit_q <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (ent_busy && !find_hit_q && conn_rd == req_q.conn_id) begin
				find_hit_q <= 1'b1;
				find_idx_q <= idx_s1;
			end
			// lowest index wins ties: replace only on a strictly smaller stamp
			if (idx_s1 == '0 || stamp_rd < lru_stamp_q) begin
				lru_idx_q   <= idx_s1;
				lru_stamp_q <= stamp_rd;
				lru_conn_q  <= conn_rd;
			end
		end
	end

`ifndef SYNTH
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("result strobe without a final state");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.busy_count <= n_q))
		else $error("busy count above effective slot count");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(conn_we || stamp_we) |-> !rd_en)
		else $error("slot memory read and written together");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted command did not raise busy");
`endif

endmodule

### tb/sv/lru_slot_pool_checker.sv
module lru_slot_pool_checker #(
	parameter int SLOTS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  lsp_pkg::req_t             req,
	input  logic                      done,
	input  lsp_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [lsp_pkg::CNT_W-1:0] cfg_wdata,
	output int                        fail_count,
	output int                        results_owed
);

	localparam int CW = lsp_pkg::CNT_W;

	logic [CW-1:0] active_cfg;
	logic          slot_taken [SLOTS];
	logic [31:0]   slot_id    [SLOTS];
	logic [31:0]   slot_used  [SLOTS];

	lsp_pkg::rsp_t expected_rsp_q [$];
	int            mismatches = 0;

	assign fail_count = mismatches;

	// Apply one command to the pool image and return the response it gives.
	function automatic lsp_pkg::rsp_t pool_apply(input lsp_pkg::req_t r);
		lsp_pkg::rsp_t res;
		int            lim;
		int            pick;
		bit            have_free;
		int            taken_n;

		lim = (active_cfg < SLOTS) ? int'(active_cfg) : SLOTS;
		res = '0;
		res.acq_status = lsp_pkg::ACQ_NONE;
		pick = 0;
		have_free = 0;
		case (r.cmd)
			lsp_pkg::CMD_ACQUIRE: begin
				if (lim == 0) begin
					res.acq_status = lsp_pkg::ACQ_FAILED;
				end else begin
					for (int i = 0; i < lim; i++) begin
						if (!have_free && !slot_taken[i]) begin
							have_free = 1;
							pick = i;
						end
					end
					if (have_free) begin
						res.acq_status = lsp_pkg::ACQ_FREE;
					end else begin
						// oldest stamp wins, lowest index on a tie
						for (int i = 1; i < lim; i++) begin
							if (slot_used[i] < slot_used[pick])
								pick = i;
						end
						res.acq_status = lsp_pkg::ACQ_RECYCLED;
						res.evicted_valid = 1'b1;
						res.displaced_id = slot_id[pick];
					end
					res.slot_out = pick[2:0];
					slot_taken[pick] = 1'b1;
					slot_id[pick] = r.conn_id;
					slot_used[pick] = r.now_stamp;
				end
			end
			lsp_pkg::CMD_TOUCH: begin
				if (int'(r.slot_index) < lim && slot_taken[r.slot_index]) begin
					slot_used[r.slot_index] = r.now_stamp;
					res.ok = 1'b1;
				end
			end
			lsp_pkg::CMD_RELEASE: begin
				if (int'(r.slot_index) < lim && slot_taken[r.slot_index]) begin
					slot_taken[r.slot_index] = 1'b0;
					res.ok = 1'b1;
				end
			end
			default: begin
				for (int i = 0; i < lim; i++) begin
					if (!res.ok && slot_taken[i] && slot_id[i] == r.conn_id) begin
						res.ok = 1'b1;
						res.slot_out = i[2:0];
					end
				end
			end
		endcase
		taken_n = 0;
		for (int i = 0; i < lim; i++)
			if (slot_taken[i])
				taken_n++;
		res.busy_count = taken_n[CW-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lsp_pkg::rsp_t want;
		int            owed_delta;

		if (!arst_n) begin
			active_cfg = CW'(8);
			for (int i = 0; i < SLOTS; i++) begin
				slot_taken[i] = 1'b0;
				slot_id[i] = '0;
				slot_used[i] = '0;
			end
			results_owed <= 0;
		end else begin
			owed_delta = 0;
			if (cfg_we)
				active_cfg = cfg_wdata;
			// retire the result first: it belongs to an earlier transfer
			if (done) begin
				owed_delta--;
				if (expected_rsp_q.size() == 0) begin
					$error("unexpected result: no command outstanding");
					mismatches++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.acq_status !== want.acq_status) begin
						$error("acq_status: expected %0d, actual %0d", want.acq_status,
							rsp.acq_status);
						mismatches++;
					end
					if (rsp.ok !== want.ok) begin
						$error("ok: expected %0d, actual %0d", want.ok, rsp.ok);
						mismatches++;
					end
					if (rsp.slot_out !== want.slot_out) begin
						$error("slot_out: expected %0d, actual %0d", want.slot_out,
							rsp.slot_out);
						mismatches++;
					end
					if (rsp.evicted_valid !== want.evicted_valid) begin
						$error("evicted_valid: expected %0d, actual %0d",
							want.evicted_valid, rsp.evicted_valid);
						mismatches++;
					end
					if (rsp.displaced_id !== want.displaced_id) begin
						$error("displaced_id: expected %h, actual %h", want.displaced_id,
							rsp.displaced_id);
						mismatches++;
					end
					if (rsp.busy_count !== want.busy_count) begin
						$error("busy_count: expected %0d, actual %0d", want.busy_count,
							rsp.busy_count);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				expected_rsp_q.push_back(pool_apply(req));
				owed_delta++;
			end
			results_owed <= results_owed + owed_delta;
		end
	end

endmodule

### tb/sv/lru_slot_pool_tb.sv
module lru_slot_pool_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int PHASE_ITEMS    = 90;
	localparam int CW             = lsp_pkg::CNT_W;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	lsp_pkg::req_t req = '0;
	logic          done;
	lsp_pkg::rsp_t rsp;
	logic          cfg_we = 1'b0;
	logic [CW-1:0] cfg_wdata = '0;

	int fail_count;
	int results_owed;
	int idle_cycles = 0;

	logic [31:0] id_pool [16];
	logic [31:0] stamp_clock = 32'd1000;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lru_slot_pool i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lru_slot_pool_checker i_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.done         (done),
		.rsp          (rsp),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one command after a random gap and hold it until the transfer.
	task automatic issue(input lsp_pkg::cmd_t c, input logic [31:0] id,
			input logic [7:0] idx, input logic [31:0] stamp);
		int gap;
		gap = $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= '{cmd: c, conn_id: id, slot_index: idx, now_stamp: stamp};
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_settled();
		start <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	task automatic set_active(input logic [CW-1:0] v);
		wait_settled();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CW-1:0] phase_active [10];
		int            pick;
		lsp_pkg::cmd_t c;
		logic [31:0]   id;
		logic [7:0]    idx;
		logic [31:0]   stamp;

		phase_active = '{4'd3, 4'd8, 4'd1, 4'd15, 4'd5, 4'd0, 4'd2, 4'd8, 4'd6, 4'd4};
		for (int i = 0; i < 16; i++)
			id_pool[i] = $urandom;
		id_pool[0] = 32'h0000_0000;
		id_pool[1] = 32'hFFFF_FFFF;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool: misses and rejected touch and release
		issue(lsp_pkg::CMD_FIND,    32'h0000_0000, 8'd0,   32'd0);
		issue(lsp_pkg::CMD_TOUCH,   32'h0000_0000, 8'd0,   32'd9);
		issue(lsp_pkg::CMD_RELEASE, 32'h0000_0000, 8'd0,   32'd0);
		issue(lsp_pkg::CMD_TOUCH,   32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
		// fill every slot, with a tie on the oldest stamp
		issue(lsp_pkg::CMD_ACQUIRE, 32'h0000_0000, 8'd0,   32'd5);
		issue(lsp_pkg::CMD_ACQUIRE, 32'hFFFF_FFFF, 8'd0,   32'hFFFF_FFFF);
		issue(lsp_pkg::CMD_ACQUIRE, 32'h1234_5678, 8'd0,   32'd3);
		issue(lsp_pkg::CMD_ACQUIRE, 32'h1234_5678, 8'd255, 32'd3);
		for (int i = 0; i < 4; i++)
			issue(lsp_pkg::CMD_ACQUIRE, 32'hC0DE_0000 + i, 8'd0, 32'd100 + i);
		// full pool: recycle, then find duplicates and extremes
		issue(lsp_pkg::CMD_ACQUIRE, 32'hA5A5_A5A5, 8'd0,   32'd200);
		issue(lsp_pkg::CMD_FIND,    32'h1234_5678, 8'd0,   32'd0);
		issue(lsp_pkg::CMD_FIND,    32'hFFFF_FFFF, 8'd0,   32'd0);
		issue(lsp_pkg::CMD_TOUCH,   32'h0000_0000, 8'd3,   32'd0);
		issue(lsp_pkg::CMD_ACQUIRE, 32'h5A5A_5A5A, 8'd0,   32'd300);
		issue(lsp_pkg::CMD_RELEASE, 32'h0000_0000, 8'd7,   32'd0);
		issue(lsp_pkg::CMD_RELEASE, 32'h0000_0000, 8'd7,   32'd0);
		issue(lsp_pkg::CMD_ACQUIRE, 32'h0000_0077, 8'd0,   32'd400);
		issue(lsp_pkg::CMD_RELEASE, 32'h0000_0000, 8'd8,   32'd0);
		// no active slots: everything hidden
		set_active(4'd0);
		issue(lsp_pkg::CMD_ACQUIRE, 32'h0000_0001, 8'd0,   32'd500);
		issue(lsp_pkg::CMD_FIND,    32'hFFFF_FFFF, 8'd0,   32'd0);
		issue(lsp_pkg::CMD_TOUCH,   32'h0000_0000, 8'd1,   32'd0);
		// count above the pool size acts as the full pool
		set_active(4'd15);
		issue(lsp_pkg::CMD_FIND,    32'hFFFF_FFFF, 8'd0,   32'd0);
		issue(lsp_pkg::CMD_RELEASE, 32'h0000_0000, 8'd8,   32'd0);
		set_active(4'd1);
		issue(lsp_pkg::CMD_ACQUIRE, 32'h0000_0002, 8'd0,   32'd600);

		for (int p = 0; p < 10; p++) begin
			set_active(phase_active[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 35)
					c = lsp_pkg::CMD_ACQUIRE;
				else if (pick < 55)
					c = lsp_pkg::CMD_TOUCH;
				else if (pick < 75)
					c = lsp_pkg::CMD_RELEASE;
				else
					c = lsp_pkg::CMD_FIND;
				id = ($urandom_range(0, 99) < 75) ? id_pool[$urandom_range(0, 15)] : $urandom;
				idx = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 8))
					: 8'($urandom_range(0, 255));
				// mostly advancing time with ties, some wild stamps
				pick = $urandom_range(0, 99);
				stamp_clock = stamp_clock + $urandom_range(0, 3);
				if (pick < 15)
					stamp = $urandom;
				else if (pick < 18)
					stamp = 32'h0000_0000;
				else if (pick < 21)
					stamp = 32'hFFFF_FFFF;
				else
					stamp = stamp_clock;
				issue(c, id, idx, stamp);
				if (n % 30 == 29)
					wait_settled();
			end
		end

		wait_settled();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_owed == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
